// ===== design/bmt_pkg.sv =====
// Package for the breakpoint match table.
// Holds table sizes, port widths, the function codes and the entry record.
// No dependencies.
`timescale 1ns / 1ps

package bmt_pkg;

   localparam int ENTRIES   = 128;
   localparam int ADDR_BITS = 16;

   localparam int FUNC_W    = 3;
   localparam int ADDRESS_W = 16;
   localparam int BANK_W    = 9;
   localparam int INDEX_W   = 7;
   localparam int SLOT_W    = 7;
   localparam int COUNT_W   = 8;

   localparam int IDX_BITS  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_BITS  = $clog2(ENTRIES + 1);

   localparam logic [BANK_W-1:0] BANK_ANY = '1;

   typedef logic [IDX_BITS-1:0] idx_type;
   typedef logic [CNT_BITS-1:0] cnt_type;

   typedef enum logic [FUNC_W-1:0] {
      FN_CHECK  = 3'd0,
      FN_ADD    = 3'd1,
      FN_TOGGLE = 3'd2,
      FN_DELETE = 3'd3,
      FN_CLEAR  = 3'd4
   } func_type;

   typedef struct packed {
      logic [ADDR_BITS-1:0] address;
      logic [BANK_W-1:0]    bank;
      logic                 enabled;
      logic                 oneshot;
   } entry_type;

endpackage

// ===== design/bmt_ram.sv =====
// Simple dual-port synchronous RAM with one write port and one read port.
// Read data is registered: it appears in the cycle after the read address. No dependencies.
`timescale 1ns / 1ps

module bmt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== design/bmt_match.sv =====
// Breakpoint comparator for one table entry against the current address and bank.
// Depends on bmt_pkg for the entry record and the wildcard bank pattern.
`timescale 1ns / 1ps

module bmt_match (
   input  bmt_pkg::entry_type                  entry,
   input  logic [bmt_pkg::ADDR_BITS-1:0]       key_address,
   input  logic [bmt_pkg::BANK_W-1:0]          key_bank,
   output logic                                hit
);
   import bmt_pkg::*;

   logic bank_ok;

   assign bank_ok = (entry.bank == BANK_ANY) || (entry.bank == key_bank);
   assign hit     = entry.enabled && (entry.address == key_address) && bank_ok;

endmodule

// ===== design/breakpoint_match_table_top.sv =====
// Breakpoint match table: an ordered table of breakpoints held in one synchronous RAM.
// Add, clear and unused codes register their result in the cycle after the transfer;
// toggle reads, then flips the entry in ST_TOGGLE. A check reads one entry per cycle in
// ST_SCAN until a hit or the last entry. Removing a one-shot hit, like a delete at index
// i, moves later entries down in ST_SHIFT, one RAM read and write per moved entry.
// Reset clears only state, count, valid; RAM is not cleared. Results cannot be stalled.
`timescale 1ns / 1ps

module breakpoint_match_table_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [bmt_pkg::FUNC_W-1:0]          req_func,
   input  logic [bmt_pkg::ADDRESS_W-1:0]       req_address,
   input  logic signed [bmt_pkg::BANK_W-1:0]   req_bank,
   input  logic                                req_temporary,
   input  logic [bmt_pkg::INDEX_W-1:0]         req_entry_index,
   output logic                                rsp_valid,
   output logic                                rsp_halt,
   output logic [bmt_pkg::SLOT_W-1:0]          rsp_hit_slot,
   output logic                                rsp_accepted,
   output logic [bmt_pkg::COUNT_W-1:0]         rsp_entry_count
);
   import bmt_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SHIFT,
      ST_TOGGLE
   } state_type;

   state_type            state_ff, state_in;
   idx_type              ptr_ff, ptr_in;
   cnt_type              cnt_ff, cnt_in;
   logic [ADDR_BITS-1:0] key_addr_ff, key_addr_in;
   logic [BANK_W-1:0]    key_bank_ff, key_bank_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_halt_ff, rsp_halt_in;
   logic [SLOT_W-1:0]    rsp_slot_ff, rsp_slot_in;
   logic                 rsp_acc_ff, rsp_acc_in;
   logic [COUNT_W-1:0]   rsp_count_ff, rsp_count_in;

   logic                 ram_we;
   idx_type              ram_waddr;
   idx_type              ram_raddr;
   entry_type            ram_wdata;
   logic [$bits(entry_type)-1:0] ram_rdata;
   entry_type            rd_entry;
   logic                 hit;

   cnt_type              ptr_ext;
   cnt_type              ptr_next;
   cnt_type              ptr_next2;
   cnt_type              req_idx_ext;
   logic                 req_idx_ok;

   assign rd_entry    = entry_type'(ram_rdata);
   assign ptr_ext     = cnt_type'(ptr_ff);
   assign ptr_next    = ptr_ext + cnt_type'(1);
   assign ptr_next2   = ptr_ext + cnt_type'(2);
   assign req_idx_ext = cnt_type'(req_entry_index);
   assign req_idx_ok  = (req_idx_ext < cnt_ff);

   bmt_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (ENTRIES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   bmt_match u_match (
      .entry       (rd_entry),
      .key_address (key_addr_ff),
      .key_bank    (key_bank_ff),
      .hit         (hit)
   );

   always_comb begin
      state_in     = state_ff;
      ptr_in       = ptr_ff;
      cnt_in       = cnt_ff;
      key_addr_in  = key_addr_ff;
      key_bank_in  = key_bank_ff;
      rsp_valid_in = 1'b0;
      rsp_halt_in  = rsp_halt_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_acc_in   = rsp_acc_ff;
      rsp_count_in = rsp_count_ff;
      ram_we       = 1'b0;
      ram_waddr    = ptr_ff;
      ram_wdata    = rd_entry;
      ram_raddr    = ptr_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               key_addr_in = req_address[ADDR_BITS-1:0];
               key_bank_in = req_bank;
               rsp_halt_in = 1'b0;
               rsp_slot_in = '0;
               rsp_acc_in  = 1'b0;
               unique case (req_func)
                  FN_CHECK: begin
                     if (cnt_ff == '0) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        ram_raddr = '0;
                        ptr_in    = '0;
                        state_in  = ST_SCAN;
                     end
                  end
                  FN_ADD: begin
                     if (cnt_ff < cnt_type'(ENTRIES)) begin
                        ram_we            = 1'b1;
                        ram_waddr         = cnt_ff[IDX_BITS-1:0];
                        ram_wdata.address = req_address[ADDR_BITS-1:0];
                        ram_wdata.bank    = req_bank;
                        ram_wdata.enabled = 1'b1;
                        ram_wdata.oneshot = req_temporary;
                        cnt_in            = cnt_ff + cnt_type'(1);
                        rsp_acc_in        = 1'b1;
                     end
                     rsp_valid_in = 1'b1;
                  end
                  FN_TOGGLE: begin
                     if (req_idx_ok) begin
                        ram_raddr = IDX_BITS'(req_entry_index);
                        ptr_in    = IDX_BITS'(req_entry_index);
                        state_in  = ST_TOGGLE;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  FN_DELETE: begin
                     if (req_idx_ok) begin
                        rsp_acc_in = 1'b1;
                        if ((req_idx_ext + cnt_type'(1)) < cnt_ff) begin
                           ram_raddr = IDX_BITS'(req_idx_ext + cnt_type'(1));
                           ptr_in    = IDX_BITS'(req_entry_index);
                           state_in  = ST_SHIFT;
                        end else begin
                           cnt_in       = cnt_ff - cnt_type'(1);
                           rsp_valid_in = 1'b1;
                        end
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  FN_CLEAR: begin
                     cnt_in       = '0;
                     rsp_acc_in   = 1'b1;
                     rsp_valid_in = 1'b1;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (hit) begin
               rsp_halt_in = 1'b1;
               rsp_slot_in = SLOT_W'(ptr_ff);
               if (rd_entry.oneshot && (ptr_next < cnt_ff)) begin
                  ram_raddr = IDX_BITS'(ptr_next);
                  state_in  = ST_SHIFT;
               end else begin
                  if (rd_entry.oneshot) begin
                     cnt_in = cnt_ff - cnt_type'(1);
                  end
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else if (ptr_next < cnt_ff) begin
               ram_raddr = IDX_BITS'(ptr_next);
               ptr_in    = IDX_BITS'(ptr_next);
            end else begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_SHIFT: begin
            ram_we    = 1'b1;
            ram_waddr = ptr_ff;
            ram_wdata = rd_entry;
            if (ptr_next2 < cnt_ff) begin
               ram_raddr = IDX_BITS'(ptr_next2);
               ptr_in    = IDX_BITS'(ptr_next);
            end else begin
               cnt_in       = cnt_ff - cnt_type'(1);
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_TOGGLE: begin
            ram_we            = 1'b1;
            ram_waddr         = ptr_ff;
            ram_wdata         = rd_entry;
            ram_wdata.enabled = ~rd_entry.enabled;
            rsp_acc_in        = 1'b1;
            rsp_valid_in      = 1'b1;
            state_in          = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (rsp_valid_in) begin
         rsp_count_in = COUNT_W'(cnt_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ptr_ff       <= ptr_in;
      key_addr_ff  <= key_addr_in;
      key_bank_ff  <= key_bank_in;
      rsp_halt_ff  <= rsp_halt_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_acc_ff   <= rsp_acc_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_halt        = rsp_halt_ff;
   assign rsp_hit_slot    = rsp_slot_ff;
   assign rsp_accepted    = rsp_acc_ff;
   assign rsp_entry_count = rsp_count_ff;

endmodule
